@@ rtl/ahd_pkg.sv @@
package ahd_pkg;

    localparam int ENV_W      = 24;
    localparam int TRIG_W     = 16;
    localparam int THR_W      = 15;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Full scale in Q1.23 and the level below which an envelope is treated as silent.
    localparam logic [ENV_W-1:0] ENV_ONE   = 24'd8388608;
    localparam logic [ENV_W-1:0] ENV_FLOOR = 24'd84;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_DECAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PUNCH_DECAY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PUNCH_START = 3'd6;

    localparam logic [THR_W-1:0]  RST_THRESHOLD   = 15'd3277;
    localparam logic [ENV_W-1:0]  RST_ATTACK_STEP = 24'd0;
    localparam logic [HOLD_W-1:0] RST_HOLD_LENGTH = 16'd0;
    localparam logic [ENV_W-1:0]  RST_AMP_DECAY   = 24'd16760439;
    localparam logic [ENV_W-1:0]  RST_SHAPE_DECAY = 24'd16760439;
    localparam logic [ENV_W-1:0]  RST_PUNCH_DECAY = 24'd16660000;
    localparam logic [ENV_W-1:0]  RST_PUNCH_START = 24'd0;

    typedef enum logic [1:0] {
        STAGE_IDLE,
        STAGE_ATTACK,
        STAGE_HOLD,
        STAGE_DECAY
    } stage_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [ENV_W-1:0]  attack_step;
        logic [HOLD_W-1:0] hold_length;
        logic [ENV_W-1:0]  amp_decay;
        logic [ENV_W-1:0]  shape_decay;
        logic [ENV_W-1:0]  punch_decay;
        logic [ENV_W-1:0]  punch_start;
    } cfg_t;

    typedef struct packed {
        logic [TRIG_W-1:0] last_trig;
        stage_t            stage;
        logic [HOLD_W-1:0] hold_left;
        logic [ENV_W-1:0]  amp;
        logic [ENV_W-1:0]  shape;
        logic [ENV_W-1:0]  punch;
        logic              gate;
    } env_state_t;

    typedef struct packed {
        logic [ENV_W-1:0] amp;
        logic [ENV_W-1:0] shape;
        logic [ENV_W-1:0] punch;
        logic             gate;
    } env_result_t;

    // Q1.23 times Q0.24, truncated toward zero.
    function automatic logic [ENV_W-1:0] scale_q24(input logic [ENV_W-1:0] x,
                                                   input logic [ENV_W-1:0] f);
        logic [2*ENV_W-1:0] p;
        begin
            p = {{ENV_W{1'b0}}, x} * {{ENV_W{1'b0}}, f};
            return p[2*ENV_W-1:ENV_W];
        end
    endfunction

endpackage

@@ rtl/ahd_cfg_regs.sv @@
module ahd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ahd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ahd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ahd_pkg::cfg_t                    cfg
);
    import ahd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= RST_THRESHOLD;
            cfg_reg.attack_step <= RST_ATTACK_STEP;
            cfg_reg.hold_length <= RST_HOLD_LENGTH;
            cfg_reg.amp_decay   <= RST_AMP_DECAY;
            cfg_reg.shape_decay <= RST_SHAPE_DECAY;
            cfg_reg.punch_decay <= RST_PUNCH_DECAY;
            cfg_reg.punch_start <= RST_PUNCH_START;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:   cfg_reg.threshold   <= cfg_data[THR_W-1:0];
                CFG_ATTACK_STEP: cfg_reg.attack_step <= cfg_data[ENV_W-1:0];
                CFG_HOLD_LENGTH: cfg_reg.hold_length <= cfg_data[HOLD_W-1:0];
                CFG_AMP_DECAY:   cfg_reg.amp_decay   <= cfg_data[ENV_W-1:0];
                CFG_SHAPE_DECAY: cfg_reg.shape_decay <= cfg_data[ENV_W-1:0];
                CFG_PUNCH_DECAY: cfg_reg.punch_decay <= cfg_data[ENV_W-1:0];
                CFG_PUNCH_START: cfg_reg.punch_start <= cfg_data[ENV_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/ahd_env_core.sv @@
module ahd_env_core (
    input  ahd_pkg::cfg_t                 cfg,
    input  ahd_pkg::env_state_t           cur,
    input  logic [ahd_pkg::TRIG_W-1:0]    trig_level,
    output ahd_pkg::env_state_t           nxt,
    output ahd_pkg::env_result_t          res
);
    import ahd_pkg::*;

    logic signed [TRIG_W-1:0] trig_s;
    logic signed [TRIG_W-1:0] last_s;
    logic signed [TRIG_W-1:0] thr_s;
    logic                     fire;

    stage_t            stage_t0;
    logic [HOLD_W-1:0] hold_t0;
    logic [ENV_W-1:0]  amp_t0;
    logic [ENV_W-1:0]  shape_t0;
    logic [ENV_W-1:0]  punch_t0;
    logic              gate_t0;

    logic [ENV_W:0]    amp_sum;
    logic [ENV_W:0]    shape_sum;
    logic [HOLD_W-1:0] hold_dec;
    logic [ENV_W-1:0]  amp_mul;
    logic [ENV_W-1:0]  shape_mul;
    logic [ENV_W-1:0]  punch_mul;
    logic              floor_hit;

    assign trig_s = $signed(trig_level);
    assign last_s = $signed(cur.last_trig);
    assign thr_s  = $signed({1'b0, cfg.threshold});
    assign fire   = (trig_s > thr_s) && (last_s <= thr_s);

    // A trigger restarts the envelope whatever stage it is in.
    always_comb
    begin
        stage_t0 = cur.stage;
        hold_t0  = cur.hold_left;
        amp_t0   = cur.amp;
        shape_t0 = cur.shape;
        punch_t0 = cur.punch;
        gate_t0  = cur.gate;
        if (fire)
        begin
            if (cfg.attack_step != '0)
            begin
                amp_t0   = '0;
                shape_t0 = '0;
                stage_t0 = STAGE_ATTACK;
            end
            else
            begin
                amp_t0   = ENV_ONE;
                shape_t0 = ENV_ONE;
                stage_t0 = (cfg.hold_length != '0) ? STAGE_HOLD : STAGE_DECAY;
            end
            hold_t0  = cfg.hold_length;
            punch_t0 = cfg.punch_start;
            gate_t0  = 1'b1;
        end
    end

    assign amp_sum   = {1'b0, amp_t0} + {1'b0, cfg.attack_step};
    assign shape_sum = {1'b0, shape_t0} + {1'b0, cfg.attack_step};
    assign hold_dec  = (hold_t0 != '0) ? hold_t0 - HOLD_W'(1) : '0;
    assign amp_mul   = scale_q24(amp_t0, cfg.amp_decay);
    assign shape_mul = scale_q24(shape_t0, cfg.shape_decay);
    // Punch decays from its pre-floor value; a floor hit forces it to zero anyway.
    assign punch_mul = scale_q24(punch_t0, cfg.punch_decay);
    assign floor_hit = (stage_t0 == STAGE_DECAY) && (amp_mul < ENV_FLOOR);

    always_comb
    begin
        nxt.last_trig = trig_level;
        nxt.stage     = stage_t0;
        nxt.hold_left = hold_t0;
        nxt.amp       = amp_t0;
        nxt.shape     = shape_t0;
        nxt.gate      = gate_t0;
        res.punch     = punch_t0;
        case (stage_t0)
            STAGE_ATTACK:
            begin
                if (amp_sum >= {1'b0, ENV_ONE})
                begin
                    nxt.amp   = ENV_ONE;
                    nxt.shape = ENV_ONE;
                    nxt.stage = (hold_t0 != '0) ? STAGE_HOLD : STAGE_DECAY;
                end
                else
                begin
                    nxt.amp   = amp_sum[ENV_W-1:0];
                    nxt.shape = (shape_sum > {1'b0, ENV_ONE}) ? ENV_ONE
                                                              : shape_sum[ENV_W-1:0];
                end
            end
            STAGE_HOLD:
            begin
                nxt.hold_left = hold_dec;
                if (hold_dec == '0)
                begin
                    nxt.stage = STAGE_DECAY;
                end
            end
            STAGE_DECAY:
            begin
                if (floor_hit)
                begin
                    nxt.amp   = '0;
                    nxt.shape = '0;
                    nxt.stage = STAGE_IDLE;
                    nxt.gate  = 1'b0;
                    res.punch = '0;
                end
                else
                begin
                    nxt.amp   = amp_mul;
                    nxt.shape = shape_mul;
                end
            end
            default: ;
        endcase
        res.amp   = nxt.amp;
        res.shape = nxt.shape;
        res.gate  = nxt.gate;
        if (floor_hit || (punch_mul < ENV_FLOOR))
        begin
            nxt.punch = '0;
        end
        else
        begin
            nxt.punch = punch_mul;
        end
    end

endmodule

@@ rtl/ahd_envelope_generator.sv @@
// Channel  Direction  Handshake           Word
// input    in         in_valid/in_stall   trig_level
// output   out        out_valid/out_stall amp_level, shape_level, punch_level, gate_on
// config   in         cfg_we              cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; an accepted word sits
// in the input register while the envelope update runs, until the output register takes its result.
// The update for a word is a trigger check, the attack adds, three parallel
// 24x24 multiplies and the floor compares, all between the two registers.
// Reset clears the handshake, the envelope state and loads the register defaults.
// The input register keeps taking words while a result waits; input stalls only
// when both registers are full and the output is stalled.
module ahd_envelope_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ahd_pkg::TRIG_W-1:0]        trig_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ahd_pkg::ENV_W-1:0]         amp_level,
    output logic [ahd_pkg::ENV_W-1:0]         shape_level,
    output logic [ahd_pkg::ENV_W-1:0]         punch_level,
    output logic                              gate_on,
    input  logic                              cfg_we,
    input  logic [ahd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ahd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ahd_pkg::*;

    cfg_t              cfg;
    env_state_t        state_reg;
    env_state_t        state_next;
    env_result_t       res_next;
    env_result_t       res_reg;
    logic              in_valid_reg;
    logic [TRIG_W-1:0] trig_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              in_take;

    ahd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ahd_env_core u_core (
        .cfg        (cfg),
        .cur        (state_reg),
        .trig_level (trig_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{last_trig: '0, stage: STAGE_IDLE, hold_left: '0,
                               amp: '0, shape: '0, punch: '0, gate: 1'b0};
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            trig_reg <= trig_level;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign amp_level   = res_reg.amp;
    assign shape_level = res_reg.shape;
    assign punch_level = res_reg.punch;
    assign gate_on     = res_reg.gate;

    // An idle envelope has its gate closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.stage == STAGE_IDLE) |-> !state_reg.gate)
        else $error("idle stage with gate open");

    // With the gate closed the envelopes sit at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !gate_on) |-> (amp_level == '0) && (shape_level == '0))
        else $error("closed gate with nonzero envelope");

    // Neither envelope ever exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (amp_level <= ENV_ONE) && (shape_level <= ENV_ONE))
        else $error("envelope above full scale");

    // A word in the input register moves on whenever the output can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_stall) |=> out_valid_reg)
        else $error("input word not advanced");

endmodule

@@ test/ahd_envelope_generator_tb.sv @@
module ahd_envelope_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ahd_pkg::*;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int STUCK_LIMIT = 3000;
    localparam int RANDOM_BATCHES = 8;
    localparam int WORDS_PER_BATCH = 200;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [TRIG_W-1:0]     trig_level = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [ENV_W-1:0]      amp_level;
    logic [ENV_W-1:0]      shape_level;
    logic [ENV_W-1:0]      punch_level;
    logic                  gate_on;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ahd_envelope_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .trig_level  (trig_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .amp_level   (amp_level),
        .shape_level (shape_level),
        .punch_level (punch_level),
        .gate_on     (gate_on),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Register copies held by the envelope predictor.
    logic [THR_W-1:0]  thr_reg;
    logic [ENV_W-1:0]  attack_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [ENV_W-1:0]  amp_decay_reg;
    logic [ENV_W-1:0]  shape_decay_reg;
    logic [ENV_W-1:0]  punch_decay_reg;
    logic [ENV_W-1:0]  punch_start_reg;

    // Envelope state of the predictor.
    int                prev_level;
    stage_t            cur_stage;
    logic [HOLD_W-1:0] hold_count;
    logic [ENV_W-1:0]  amp_q;
    logic [ENV_W-1:0]  shape_q;
    logic [ENV_W-1:0]  punch_q;
    logic              gate_q;

    logic [TRIG_W-1:0] trig_backlog[$];
    env_result_t       expected_levels[$];
    env_result_t       want;
    int                words_queued = 0;
    int                words_accepted = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                failures = 0;
    int                stuck_cycles = 0;

    function automatic logic [ENV_W-1:0] times_q24(input logic [ENV_W-1:0] x,
                                                   input logic [ENV_W-1:0] f);
        logic [2*ENV_W-1:0] wide;
        wide = {{ENV_W{1'b0}}, x} * {{ENV_W{1'b0}}, f};
        return wide[2*ENV_W-1:ENV_W];
    endfunction

    function automatic env_result_t advance_envelope(input logic [TRIG_W-1:0] word);
        int            level;
        int            thr;
        logic [ENV_W:0] amp_sum;
        logic [ENV_W:0] shape_sum;
        env_result_t   res;
        level = int'($signed(word));
        thr = int'(thr_reg);
        if (level > thr && prev_level <= thr)
        begin
            if (attack_reg != '0)
            begin
                amp_q = '0;
                shape_q = '0;
                cur_stage = STAGE_ATTACK;
            end
            else
            begin
                amp_q = ENV_ONE;
                shape_q = ENV_ONE;
                cur_stage = (hold_reg != '0) ? STAGE_HOLD : STAGE_DECAY;
            end
            hold_count = hold_reg;
            punch_q = punch_start_reg;
            gate_q = 1'b1;
        end
        prev_level = level;
        case (cur_stage)
            STAGE_ATTACK:
            begin
                amp_sum = {1'b0, amp_q} + {1'b0, attack_reg};
                shape_sum = {1'b0, shape_q} + {1'b0, attack_reg};
                if (amp_sum >= {1'b0, ENV_ONE})
                begin
                    amp_q = ENV_ONE;
                    shape_q = ENV_ONE;
                    cur_stage = (hold_count != '0) ? STAGE_HOLD : STAGE_DECAY;
                end
                else
                begin
                    amp_q = amp_sum[ENV_W-1:0];
                    shape_q = (shape_sum > {1'b0, ENV_ONE}) ? ENV_ONE : shape_sum[ENV_W-1:0];
                end
            end
            STAGE_HOLD:
            begin
                if (hold_count != '0)
                    hold_count = hold_count - HOLD_W'(1);
                if (hold_count == '0)
                    cur_stage = STAGE_DECAY;
            end
            STAGE_DECAY:
            begin
                amp_q = times_q24(amp_q, amp_decay_reg);
                shape_q = times_q24(shape_q, shape_decay_reg);
                if (amp_q < ENV_FLOOR)
                begin
                    amp_q = '0;
                    shape_q = '0;
                    punch_q = '0;
                    cur_stage = STAGE_IDLE;
                    gate_q = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        res.amp = amp_q;
        res.shape = shape_q;
        res.punch = punch_q;
        res.gate = gate_q;
        // The punch output is taken before its own decay for this sample.
        punch_q = times_q24(punch_q, punch_decay_reg);
        if (punch_q < ENV_FLOOR)
            punch_q = '0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            trig_level <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_levels.push_back(advance_envelope(trig_level));
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (trig_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    trig_level <= trig_backlog.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stuck_cycles = 0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    failures++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (amp_level !== want.amp)
                    begin
                        $error("amp_level: expected %0d, got %0d", want.amp, amp_level);
                        failures++;
                    end
                    if (shape_level !== want.shape)
                    begin
                        $error("shape_level: expected %0d, got %0d", want.shape, shape_level);
                        failures++;
                    end
                    if (punch_level !== want.punch)
                    begin
                        $error("punch_level: expected %0d, got %0d", want.punch, punch_level);
                        failures++;
                    end
                    if (gate_on !== want.gate)
                    begin
                        $error("gate_on: expected %0d, got %0d", want.gate, gate_on);
                        failures++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic reset_predictor();
        thr_reg = RST_THRESHOLD;
        attack_reg = RST_ATTACK_STEP;
        hold_reg = RST_HOLD_LENGTH;
        amp_decay_reg = RST_AMP_DECAY;
        shape_decay_reg = RST_SHAPE_DECAY;
        punch_decay_reg = RST_PUNCH_DECAY;
        punch_start_reg = RST_PUNCH_START;
        prev_level = 0;
        cur_stage = STAGE_IDLE;
        hold_count = '0;
        amp_q = '0;
        shape_q = '0;
        punch_q = '0;
        gate_q = 1'b0;
    endtask

    // Drives one register write, which lands at the next rising edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_THRESHOLD:   thr_reg = data[THR_W-1:0];
            CFG_ATTACK_STEP: attack_reg = data;
            CFG_HOLD_LENGTH: hold_reg = data[HOLD_W-1:0];
            CFG_AMP_DECAY:   amp_decay_reg = data;
            CFG_SHAPE_DECAY: shape_decay_reg = data;
            CFG_PUNCH_DECAY: punch_decay_reg = data;
            CFG_PUNCH_START: punch_start_reg = data;
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic queue_word(input logic [TRIG_W-1:0] word);
        trig_backlog.push_back(word);
        words_queued++;
    endtask

    task automatic wait_drained();
        while (words_accepted != words_queued || expected_levels.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ENV_W-1:0] pick_decay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(0, 24'hFFFFFF));
            default: return 24'($urandom_range(12000000, 16500000));
        endcase
    endfunction

    task automatic load_random_setting();
        logic [THR_W-1:0]  thr_val;
        logic [ENV_W-1:0]  step_val;
        logic [HOLD_W-1:0] hold_val;
        logic [ENV_W-1:0]  punch_val;
        case ($urandom_range(0, 3))
            0:       thr_val = '0;
            1:       thr_val = 15'($urandom_range(1, 1000));
            2:       thr_val = 15'($urandom_range(1001, 30000));
            default: thr_val = 15'($urandom_range(30001, 32766));
        endcase
        case ($urandom_range(0, 3))
            0:       step_val = '0;
            1:       step_val = ENV_ONE;
            2:       step_val = 24'($urandom_range(20000, 400000));
            default: step_val = 24'($urandom_range(400001, ENV_ONE));
        endcase
        case ($urandom_range(0, 7))
            0, 1:    hold_val = '0;
            2, 3, 4: hold_val = 16'($urandom_range(1, 8));
            5, 6:    hold_val = 16'($urandom_range(9, 60));
            default: hold_val = 16'hFFFF;
        endcase
        case ($urandom_range(0, 3))
            0:       punch_val = '0;
            1:       punch_val = 24'd13421773;
            2:       punch_val = 24'($urandom_range(1, 13421773));
            default: punch_val = 24'($urandom_range(1, 200));
        endcase
        // Bits above a narrow register's width carry junk and must be dropped.
        write_reg(CFG_THRESHOLD, {9'($urandom()), thr_val});
        write_reg(CFG_ATTACK_STEP, step_val);
        write_reg(CFG_HOLD_LENGTH, {8'($urandom()), hold_val});
        write_reg(CFG_AMP_DECAY, pick_decay());
        write_reg(CFG_SHAPE_DECAY, pick_decay());
        write_reg(CFG_PUNCH_DECAY, pick_decay());
        write_reg(CFG_PUNCH_START, punch_val);
        cfg_we <= 1'b0;
    endtask

    // Mostly a single word above the threshold followed by a run at or below it, so
    // that envelopes get through attack, hold and decay; the rest is noise.
    task automatic queue_random_words(input int count);
        int n;
        int thr;
        int gap;
        int k;
        n = 0;
        thr = int'(thr_reg);
        while (n < count)
        begin
            if ($urandom_range(0, 9) < 8 && thr < 32767)
            begin
                queue_word(16'($urandom_range(thr + 1, 32767)));
                n++;
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                  : $urandom_range(5, 150);
                for (k = 0; k < gap; k++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        queue_word(16'(thr));
                    else
                        queue_word(16'(int'($urandom_range(0, thr + 32768)) - 32768));
                    n++;
                end
            end
            else
            begin
                gap = $urandom_range(1, 6);
                for (k = 0; k < gap; k++)
                begin
                    queue_word(16'($urandom_range(0, 65535)));
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        int b;
        reset_predictor();
        send_idle_pct = 9;
        recv_idle_pct = 61;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: instant attack, no hold, threshold equality and
        // a retrigger while the envelope decays.
        queue_word(16'd0);
        queue_word(16'h8000);
        queue_word(16'd3277);
        queue_word(16'd3278);
        queue_word(16'h7FFF);
        queue_word(16'hFFFF);
        queue_word(16'h7FFF);
        queue_word(16'd0);
        wait_drained();

        // Full-scale attack in one step, a short hold, decay straight to the
        // floor and a punch that drops under the floor after one sample.
        write_reg(CFG_THRESHOLD, 24'hFF8000);
        write_reg(CFG_ATTACK_STEP, ENV_ONE);
        write_reg(CFG_HOLD_LENGTH, 24'hAB0002);
        write_reg(CFG_AMP_DECAY, 24'd0);
        write_reg(CFG_SHAPE_DECAY, 24'hFFFFFF);
        write_reg(CFG_PUNCH_DECAY, 24'd100);
        write_reg(CFG_PUNCH_START, 24'd13421773);
        write_reg(CFG_UNUSED, 24'($urandom()));
        cfg_we <= 1'b0;
        queue_word(16'd1);
        queue_word(16'd0);
        queue_word(16'd0);
        queue_word(16'h8000);
        queue_word(16'd0);
        wait_drained();

        // Ramp that overshoots full scale, then a restart during decay.
        write_reg(CFG_THRESHOLD, 24'd100);
        write_reg(CFG_ATTACK_STEP, 24'd3000000);
        write_reg(CFG_HOLD_LENGTH, 24'd0);
        write_reg(CFG_AMP_DECAY, 24'd8388608);
        write_reg(CFG_SHAPE_DECAY, 24'd12582912);
        write_reg(CFG_PUNCH_DECAY, 24'd16000000);
        write_reg(CFG_PUNCH_START, 24'd4000000);
        cfg_we <= 1'b0;
        queue_word(16'd101);
        queue_word(16'd0);
        queue_word(16'd0);
        queue_word(16'd0);
        queue_word(16'd200);
        repeat (4) queue_word(16'd0);
        wait_drained();

        // Highest threshold: no level can exceed it.
        write_reg(CFG_THRESHOLD, 24'h007FFF);
        cfg_we <= 1'b0;
        queue_word(16'h7FFF);
        queue_word(16'h8000);
        queue_word(16'h7FFF);
        wait_drained();

        for (b = 0; b < RANDOM_BATCHES; b++)
        begin
            if (b < 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 61;
            end
            else if (b < 6)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_random_setting();
            queue_random_words(WORDS_PER_BATCH);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (expected_levels.size() != 0)
        begin
            $error("%0d result words never arrived", expected_levels.size());
            failures++;
        end
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
